// ===== hdl/swfa_pkg.sv =====
`default_nettype none
package swfa_pkg;

   // Fixed field widths
   localparam int DIM_W    = 13;
   localparam int POS_W    = 25;
   localparam int BYTE_W   = 8;
   localparam int DATA_W   = 64;
   localparam int ADDR_W   = 5;

   // Defaults for the top-level parameters
   localparam int SYNC_BYTES_DEF = 8;
   localparam int MAX_DIM_DEF    = 4096;

   // Register indexes (byte address is 8 * index)
   localparam logic [1:0] REG_SYNC_WORD    = 2'd0;
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

   // Register reset values
   localparam logic [DATA_W-1:0] SYNC_WORD_RST    = 64'h0806_0808_0808_0808;
   localparam logic [DIM_W-1:0]  FRAME_WIDTH_RST  = 13'd640;
   localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST = 13'd480;

   typedef struct packed {
      logic [DATA_W-1:0] sync_word;
      logic [DIM_W-1:0]  frame_width;
      logic [DIM_W-1:0]  frame_height;
   } cfg_type;

endpackage
`default_nettype wire

// ===== hdl/swfa_req_if.sv =====
`default_nettype none
interface swfa_req_if
   import swfa_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_in;
   logic              packet_end;

   modport source (output valid, output byte_in, output packet_end, input ready);
   modport sink   (input valid, input byte_in, input packet_end, output ready);
endinterface
`default_nettype wire

// ===== hdl/swfa_rsp_if.sv =====
`default_nettype none
interface swfa_rsp_if
   import swfa_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] pixel_out;
   logic              frame_first;
   logic              frame_last;

   modport source (output valid, output pixel_out, output frame_first, output frame_last,
                   input ready);
   modport sink   (input valid, input pixel_out, input frame_first, input frame_last,
                   output ready);
endinterface
`default_nettype wire

// ===== hdl/sync_word_frame_aligner_core.sv =====
`default_nettype none
// Sync-word frame aligner. Camera bytes enter on req_chan; until the sync word
// (the low SYNC_BYTES bytes of register sync_word, first byte most significant,
// wholly inside one packet) is seen, every byte is dropped. After lock the block
// drops frame_width*(frame_height-1) bytes counted from the first sync byte, then
// forwards every byte on rsp_chan in frames of frame_width*frame_height bytes
// with first and last marks. Lock is cleared by reset only. One byte is taken per
// clock: each request passes an input register, one pass of compare, counter and
// multiplier logic, and a result register. A result the receiver has not yet
// taken holds the input register and so stalls req_chan.
// Registers sit at byte addresses 0, 8 and 16 of the 64-bit csr_ port; write
// them only while the block is idle.
module sync_word_frame_aligner_core
   import swfa_pkg::*;
   #(
   parameter int SYNC_BYTES = SYNC_BYTES_DEF,
   parameter int MAX_DIM    = MAX_DIM_DEF
   )
   (
   input  wire logic              clock,
   input  wire logic              reset,
   swfa_req_if.sink               req_chan,
   swfa_rsp_if.source             rsp_chan,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output logic      [DATA_W-1:0] csr_prdata,
   output logic                   csr_pready
   );

   cfg_type cfg;

   swfa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   swfa_align #(
      .SYNC_BYTES (SYNC_BYTES),
      .MAX_DIM    (MAX_DIM)
   ) u_align (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire

// ===== hdl/swfa_csr.sv =====
`default_nettype none
module swfa_csr
   import swfa_pkg::*;
   (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output logic      [DATA_W-1:0] csr_prdata,
   output logic                   csr_pready,
   output cfg_type                cfg
   );

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[ADDR_W-1:3];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_SYNC_WORD:    cfg_in.sync_word    = csr_pwdata;
            REG_FRAME_WIDTH:  cfg_in.frame_width  = csr_pwdata[DIM_W-1:0];
            REG_FRAME_HEIGHT: cfg_in.frame_height = csr_pwdata[DIM_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_word    <= SYNC_WORD_RST;
         cfg_ff.frame_width  <= FRAME_WIDTH_RST;
         cfg_ff.frame_height <= FRAME_HEIGHT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         REG_SYNC_WORD:    csr_prdata = cfg_ff.sync_word;
         REG_FRAME_WIDTH:  csr_prdata = DATA_W'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT: csr_prdata = DATA_W'(cfg_ff.frame_height);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== hdl/swfa_align.sv =====
`default_nettype none
module swfa_align
   import swfa_pkg::*;
   #(
   parameter int SYNC_BYTES = SYNC_BYTES_DEF,
   parameter int MAX_DIM    = MAX_DIM_DEF
   )
   (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   swfa_req_if.sink     req_chan,
   swfa_rsp_if.source   rsp_chan
   );

   localparam int WIN_W  = 8 * SYNC_BYTES;
   localparam int FILL_W = $clog2(SYNC_BYTES + 1);
   localparam int PROD_W = 2 * DIM_W;

   // Input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_pend_ff;

   // Alignment state
   logic [WIN_W-1:0]  win_ff, win_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              locked_ff, locked_in;
   logic [POS_W-1:0]  skip_ff, skip_in;
   logic [POS_W-1:0]  pos_ff, pos_in;

   // Result register
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_first_ff, out_first_in;
   logic              out_last_ff, out_last_in;

   logic              advance;
   logic [DIM_W-1:0]  eff_w, eff_h, factor;
   logic [PROD_W-1:0] prod;
   logic [WIN_W-1:0]  win_sh;
   logic [FILL_W-1:0] fill_inc;
   logic              match;
   logic              emit;
   logic              last;

   // Move the held request on once the result register is free
   assign advance          = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !in_valid_ff || advance;
   assign in_valid_in      = req_chan.valid ? 1'b1 : (in_valid_ff && !advance);

   // Clamp the dimensions; one multiplier serves skip length and frame size
   always_comb begin
      eff_w = cfg.frame_width;
      if (eff_w == '0) eff_w = DIM_W'(1);
      else if (eff_w > DIM_W'(MAX_DIM)) eff_w = DIM_W'(MAX_DIM);
      eff_h = cfg.frame_height;
      if (eff_h < DIM_W'(2)) eff_h = DIM_W'(2);
      else if (eff_h > DIM_W'(MAX_DIM)) eff_h = DIM_W'(MAX_DIM);
      factor = locked_ff ? eff_h : (eff_h - DIM_W'(1));
   end

   assign prod = PROD_W'(eff_w) * PROD_W'(factor);

   // Hunt for the sync word
   assign win_sh   = (win_ff << BYTE_W) | WIN_W'(in_byte_ff);
   assign fill_inc = (fill_ff < FILL_W'(SYNC_BYTES)) ? fill_ff + FILL_W'(1) : fill_ff;
   assign match    = (fill_inc >= FILL_W'(SYNC_BYTES)) && (win_sh == cfg.sync_word[WIN_W-1:0]);
   assign last     = (PROD_W'(pos_ff) >= (prod - PROD_W'(1)));

   always_comb begin
      win_in       = win_ff;
      fill_in      = fill_ff;
      locked_in    = locked_ff;
      skip_in      = skip_ff;
      pos_in       = pos_ff;
      emit         = 1'b0;
      out_byte_in  = out_byte_ff;
      out_first_in = out_first_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         if (!locked_ff) begin
            win_in  = win_sh;
            fill_in = fill_inc;
            if (match) begin
               locked_in = 1'b1;
               skip_in   = (prod > PROD_W'(SYNC_BYTES))
                           ? POS_W'(prod - PROD_W'(SYNC_BYTES)) : '0;
            end
            // Drop the window at a packet boundary
            if (in_pend_ff) begin
               win_in  = '0;
               fill_in = '0;
            end
         end else if (skip_ff != '0) begin
            skip_in = skip_ff - POS_W'(1);
         end else begin
            emit         = 1'b1;
            out_byte_in  = in_byte_ff;
            out_first_in = (pos_ff == '0);
            out_last_in  = last;
            pos_in       = last ? '0 : pos_ff + POS_W'(1);
         end
      end
   end

   assign out_valid_in = advance ? emit : (out_valid_ff && !rsp_chan.ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         win_ff       <= '0;
         fill_ff      <= '0;
         locked_ff    <= 1'b0;
         skip_ff      <= '0;
         pos_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         win_ff       <= win_in;
         fill_ff      <= fill_in;
         locked_ff    <= locked_in;
         skip_ff      <= skip_in;
         pos_ff       <= pos_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         in_byte_ff <= req_chan.byte_in;
         in_pend_ff <= req_chan.packet_end;
      end
      out_byte_ff  <= out_byte_in;
      out_first_ff <= out_first_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.pixel_out   = out_byte_ff;
   assign rsp_chan.frame_first = out_first_ff;
   assign rsp_chan.frame_last  = out_last_ff;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
module tb_top;
   import swfa_pkg::*;

   localparam int          SYNC_LEN    = SYNC_BYTES_DEF;
   localparam int          SETTLE      = 4;
   localparam int          HOLD_CYCLES = 200;
   localparam int          SHOW_LIMIT  = 20;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam logic [1:0]  REG_UNUSED  = 2'd3;
   localparam logic [DATA_W-1:0] SYNC_MASK =
      {DATA_W{1'b1}} >> (DATA_W - BYTE_W * SYNC_LEN);

   typedef struct packed {
      logic [BYTE_W-1:0] pixel;
      logic              first;
      logic              last;
   } pixel_rec_type;

   typedef enum int {MISS_SPLIT, MISS_SHORT, MISS_FLIP, MISS_NOISE} miss_kind_type;
   typedef enum int {RX_OPEN, RX_CHOPPY, RX_SHUT} rx_mode_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0] csr_paddr   = '0;
   logic [DATA_W-1:0] csr_pwdata  = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   swfa_req_if req_bus ();
   swfa_rsp_if rsp_bus ();

   // Predictor copy of the registers and of the aligner state
   logic [DATA_W-1:0] exp_sync       = SYNC_WORD_RST;
   logic [DIM_W-1:0]  exp_width_reg  = FRAME_WIDTH_RST;
   logic [DIM_W-1:0]  exp_height_reg = FRAME_HEIGHT_RST;
   logic [DATA_W-1:0] recent_bytes   = '0;
   int unsigned       recent_count   = 0;
   logic              in_lock        = 1'b0;
   logic [POS_W-1:0]  bytes_to_drop  = '0;
   logic [POS_W-1:0]  frame_offset   = '0;

   pixel_rec_type pixel_queue[$];
   int            error_count = 0;
   int unsigned   cycle_count = 0;

   // Sender burst state and long hold-off orders for the receiver
   bit          steady      = 1'b0;
   int unsigned burst_left  = 0;
   int unsigned hold_orders = 0;

   sync_word_frame_aligner_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abandon the run if it hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] raw,
                                             input int unsigned lo);
      if (raw < lo) return lo;
      if (raw > MAX_DIM_DEF) return MAX_DIM_DEF;
      return raw;
   endfunction

   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   function automatic logic rand_flag();
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < SHOW_LIMIT)
         $display("[%0t] mismatch in %s: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   // Advance the aligner state by one byte and queue the pixel it forwards
   task automatic predict_pixel(input logic [BYTE_W-1:0] b, input logic pe);
      int unsigned   total;
      int unsigned   size;
      pixel_rec_type rec;
      if (!in_lock) begin
         recent_bytes = {recent_bytes[DATA_W-BYTE_W-1:0], b};
         if (recent_count < SYNC_LEN) recent_count++;
         // the byte carrying the packet end is still compared before the clear
         if (recent_count >= SYNC_LEN &&
             (recent_bytes & SYNC_MASK) == (exp_sync & SYNC_MASK)) begin
            total = clamp_dim(exp_width_reg, 1) * (clamp_dim(exp_height_reg, 2) - 1);
            in_lock = 1'b1;
            // the sync bytes already seen count toward the drop
            bytes_to_drop = (total > SYNC_LEN) ? POS_W'(total - SYNC_LEN) : '0;
         end
         if (pe) begin
            recent_bytes = '0;
            recent_count = 0;
         end
      end else if (bytes_to_drop != 0) begin
         bytes_to_drop--;
      end else begin
         size = clamp_dim(exp_width_reg, 1) * clamp_dim(exp_height_reg, 2);
         rec.pixel = b;
         rec.first = (frame_offset == 0);
         rec.last  = (frame_offset >= size - 1);
         frame_offset = rec.last ? '0 : frame_offset + 1'b1;
         pixel_queue.push_back(rec);
      end
   endtask

   // Predict on each accepted request, then check each accepted result
   always @(posedge clock) begin : scoreboard
      pixel_rec_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            predict_pixel(req_bus.byte_in, req_bus.packet_end);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pixel_queue.size() == 0) begin
               report_mismatch("result with none pending", rsp_bus.pixel_out, '0);
            end else begin
               want = pixel_queue.pop_front();
               if (rsp_bus.pixel_out !== want.pixel)
                  report_mismatch("pixel_out", rsp_bus.pixel_out, want.pixel);
               if (rsp_bus.frame_first !== want.first)
                  report_mismatch("frame_first", rsp_bus.frame_first, want.first);
               if (rsp_bus.frame_last !== want.last)
                  report_mismatch("frame_last", rsp_bus.frame_last, want.last);
            end
         end
      end
   end

   // Receiver: open, choppy and shut stretches, plus long hold-offs on order
   initial begin : rx_pattern
      rx_mode_type mode;
      int unsigned mode_left;
      int unsigned hold_left;
      int unsigned hold_seen;
      int unsigned pick;
      mode      = RX_OPEN;
      mode_left = 0;
      hold_left = 0;
      hold_seen = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_orders) begin
            hold_seen = hold_orders;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               pick = $urandom_range(0, 3);
               mode = (pick < 2) ? RX_OPEN : ((pick == 2) ? RX_CHOPPY : RX_SHUT);
               mode_left = (mode == RX_SHUT) ? $urandom_range(1, 12) : $urandom_range(4, 40);
            end
            mode_left--;
            case (mode)
               RX_OPEN:   rsp_bus.ready <= 1'b1;
               RX_CHOPPY: rsp_bus.ready <= rand_flag();
               default:   rsp_bus.ready <= 1'b0;
            endcase
         end
      end
   end

   // Offer one request and hold it until taken; pause between bursts
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic pe);
      int unsigned gap;
      req_bus.valid      <= 1'b1;
      req_bus.byte_in    <= b;
      req_bus.packet_end <= pe;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (!steady) begin
         if (burst_left != 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Send pattern bytes first..first+count-1, optionally closing the packet
   task automatic send_run(input logic [DATA_W-1:0] word, input int first,
                           input int count, input bit end_pkt);
      for (int i = first; i < first + count; i++)
         send_byte(word[BYTE_W*(SYNC_LEN-i)-1 -: BYTE_W],
                   end_pkt && (i == first + count - 1));
   endtask

   // Drop valid, wait for every pending result, then let the pipeline settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_SYNC_WORD:    exp_sync       = data;
         REG_FRAME_WIDTH:  exp_width_reg  = data[DIM_W-1:0];
         REG_FRAME_HEIGHT: exp_height_reg = data[DIM_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // One near miss of the sync pattern (split, short, flipped or noise), always closed by a packet end
   task automatic send_near_miss();
      miss_kind_type     kind;
      int                cut;
      int                len;
      logic [DATA_W-1:0] bent;
      kind = miss_kind_type'($urandom_range(0, 3));
      case (kind)
         MISS_SPLIT: begin
            cut = $urandom_range(1, SYNC_LEN - 1);
            send_run(exp_sync, 0, cut, 1'b1);
            send_run(exp_sync, cut, SYNC_LEN - cut, 1'b1);
         end
         MISS_SHORT: begin
            len = $urandom_range(1, SYNC_LEN - 1);
            send_run(exp_sync, $urandom_range(0, SYNC_LEN - len), len, 1'b1);
         end
         MISS_FLIP: begin
            cut  = $urandom_range(0, SYNC_LEN - 1);
            bent = exp_sync ^ (DATA_W'($urandom_range(1, 255)) << (BYTE_W * cut));
            send_run(bent, 0, SYNC_LEN, 1'b1);
         end
         default: begin
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++)
               send_byte(rand_byte(), i == len - 1);
         end
      endcase
   endtask

   // Hunt: truncated and split patterns, field extremes, all-ones and zero words
   task automatic test_hunt_directed();
      send_run(exp_sync, 0, SYNC_LEN - 1, 1'b1);
      send_run(exp_sync, 0, 3, 1'b1);
      send_run(exp_sync, 3, SYNC_LEN - 3, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      drain();
      csr_write(REG_SYNC_WORD, {DATA_W{1'b1}});
      send_run(exp_sync ^ DATA_W'(1), 0, SYNC_LEN, 1'b1);
      drain();
      csr_write(REG_SYNC_WORD, '0);
      send_run(exp_sync, 0, SYNC_LEN - 1, 1'b1);
      drain();
   endtask

   task automatic test_hunt_random(input int unsigned misses);
      int unsigned pick;
      for (int phase = 0; phase < 4; phase++) begin
         pick = $urandom_range(0, 3);
         if (pick == 0)      csr_write(REG_SYNC_WORD, '0);
         else if (pick == 1) csr_write(REG_SYNC_WORD, {DATA_W{1'b1}});
         else                csr_write(REG_SYNC_WORD, {$urandom, $urandom});
         repeat (misses) send_near_miss();
         drain();
      end
   endtask

   // Lock on a pattern that ends a longer packet, then cross the drop
   task automatic test_lock();
      logic [DATA_W-1:0] data;
      data = {$urandom, $urandom};
      data[DIM_W-1:0] = DIM_W'($urandom_range(0, 6));
      csr_write(REG_FRAME_WIDTH, data);
      data = {$urandom, $urandom};
      data[DIM_W-1:0] = DIM_W'($urandom_range(0, 5));
      csr_write(REG_FRAME_HEIGHT, data);
      csr_write(REG_SYNC_WORD, {$urandom, $urandom});
      repeat (3) send_byte(rand_byte(), 1'b0);
      send_run(exp_sync, 0, SYNC_LEN, 1'b1);
      repeat (24) send_byte(rand_byte(), rand_flag());
      drain();
   endtask

   // A zero width and a height of one clamp up to the smallest frame
   task automatic test_min_frame();
      csr_write(REG_FRAME_WIDTH, '0);
      csr_write(REG_FRAME_HEIGHT, DATA_W'(1));
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      repeat (4) send_byte(rand_byte(), rand_flag());
      drain();
   endtask

   task automatic test_dim_extremes();
      csr_write(REG_FRAME_WIDTH, DATA_W'(8191));
      csr_write(REG_FRAME_HEIGHT, DATA_W'(4096));
      repeat (5) send_byte(rand_byte(), rand_flag());
      drain();
      csr_write(REG_FRAME_WIDTH, DATA_W'(4096));
      csr_write(REG_FRAME_HEIGHT, DATA_W'(8191));
      repeat (3) send_byte(rand_byte(), rand_flag());
      drain();
      // shrink below the current position: the next byte closes the frame
      csr_write(REG_FRAME_WIDTH, {{(DATA_W-DIM_W){1'b1}}, DIM_W'(2)});
      csr_write(REG_FRAME_HEIGHT, DATA_W'(2));
      repeat (6) send_byte(rand_byte(), rand_flag());
      drain();
   endtask

   // Writes to the unused slot and to the sync word once locked change nothing
   task automatic test_register_decode();
      csr_write(REG_UNUSED, {$urandom, $urandom});
      csr_write(REG_SYNC_WORD, {$urandom, $urandom});
      repeat (8) send_byte(rand_byte(), rand_flag());
      drain();
   endtask

   // Hold the receiver off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      csr_write(REG_FRAME_WIDTH, DATA_W'(3));
      csr_write(REG_FRAME_HEIGHT, DATA_W'(4));
      steady = 1'b1;
      hold_orders++;
      repeat (60) send_byte(rand_byte(), rand_flag());
      steady = 1'b0;
      drain();
   endtask

   task automatic test_random_frames(input int unsigned total_items);
      int unsigned       sent;
      int unsigned       chunk;
      logic [DATA_W-1:0] data;
      sent = 0;
      while (sent < total_items) begin
         data = {$urandom, $urandom};
         data[DIM_W-1:0] = DIM_W'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 8191)
                                                                : $urandom_range(0, 12));
         if ($urandom_range(0, 3) != 0) csr_write(REG_FRAME_WIDTH, data);
         data = {$urandom, $urandom};
         data[DIM_W-1:0] = DIM_W'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 8191)
                                                                : $urandom_range(0, 8));
         if ($urandom_range(0, 3) != 0) csr_write(REG_FRAME_HEIGHT, data);
         if ($urandom_range(0, 7) == 0)
            csr_write(($urandom_range(0, 1) == 0) ? REG_UNUSED : REG_SYNC_WORD,
                      {$urandom, $urandom});
         steady = ($urandom_range(0, 3) == 0);
         chunk  = $urandom_range(10, 120);
         repeat (chunk) send_byte(rand_byte(), rand_flag());
         steady = 1'b0;
         drain();
         sent += chunk;
      end
   endtask

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.byte_in    = '0;
      req_bus.packet_end = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_hunt_directed();
      test_hunt_random(12);
      test_lock();
      test_min_frame();
      test_dim_extremes();
      test_register_decode();
      test_backpressure();
      test_random_frames(1000);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
